### src/encoder_knob_motor_drive_defines.svh
// ----------------------------------------------------------------------------
// encoder_knob_motor_drive assertion macros
// Shared property shorthands for the checker of the knob motor drive.
// ----------------------------------------------------------------------------
`ifndef ENCODER_KNOB_MOTOR_DRIVE_DEFINES_SVH
`define ENCODER_KNOB_MOTOR_DRIVE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define EKMD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define EKMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ekmd_pkg.sv
// ----------------------------------------------------------------------------
// ekmd_pkg
// Widths, constants and the stage record of the knob motor drive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ekmd_pkg;

    // Encoder counts per unit of target movement (power of two, 1..16)
    localparam int COUNTS_PER_STEP = 4;

    // Field widths
    localparam int PCT_W   = 7;
    localparam int CNT_W   = 16;
    localparam int DUTY_W  = 8;
    localparam int TGT_W   = 9;
    localparam int PROD_W  = PCT_W + DUTY_W;
    localparam int ACC_W   = CNT_W + 1;
    localparam int SUM_W   = ACC_W + 1;
    localparam int REM_W   = $clog2(COUNTS_PER_STEP) + 1;

    // Percent scaling: floor(x / 100) == (x * 5243) >> 19 for x < 25600
    localparam int PCT_FULL  = 100;
    localparam int RCP_W     = 13;
    localparam int PCT_RECIP = 5243;
    localparam int PCT_SHIFT = 19;
    localparam int SCL_W     = PROD_W + RCP_W;

    // Register reset values
    localparam logic [DUTY_W-1:0] MAX_DUTY_RST  = 8'd99;
    localparam logic [DUTY_W-1:0] MIN_START_RST = 8'd10;

    // Register byte addresses
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_MAX_DUTY  = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_MIN_START = 3'd4;

    // Stream widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    // Work handed from the input stage to the update stage
    typedef struct packed {
        logic                     ui_ok;
        logic [PROD_W-1:0]        product;
        logic                     move;
        logic signed [CNT_W-1:0]  delta;
    } stage_t;

endpackage

### src/ekmd_front.sv
// ----------------------------------------------------------------------------
// ekmd_front
// Input register: percent product, count difference and count history.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ekmd_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             ui_valid,
    input  logic [ekmd_pkg::PCT_W-1:0]       ui_percent,
    input  logic [ekmd_pkg::CNT_W-1:0]       encoder_count,
    input  logic [ekmd_pkg::DUTY_W-1:0]      max_duty,
    input  logic                             core_ready,
    output logic                             stage_valid,
    output ekmd_pkg::stage_t                 stage
);

    logic                              valid_reg;
    ekmd_pkg::stage_t                  stage_reg;
    ekmd_pkg::stage_t                  stage_next;
    logic [ekmd_pkg::CNT_W-1:0]        prev_count_reg;
    logic                              primed_reg;
    logic                              accept;

    assign in_ready    = !valid_reg || core_ready;
    assign accept      = in_valid && in_ready;
    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

    // Prepare the item: percent times limit, wrapped count difference
    always_comb
    begin
        stage_next.ui_ok   = ui_valid &&
                             (ui_percent <= ekmd_pkg::PCT_W'(ekmd_pkg::PCT_FULL));
        stage_next.product = ekmd_pkg::PROD_W'(ui_percent) * ekmd_pkg::PROD_W'(max_duty);
        stage_next.delta   = $signed(encoder_count - prev_count_reg);
        stage_next.move    = primed_reg && (encoder_count != prev_count_reg);
    end

    // Control and count history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            primed_reg     <= 1'b0;
            prev_count_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                valid_reg      <= 1'b1;
                primed_reg     <= 1'b1;
                prev_count_reg <= encoder_count;
            end
            else if (core_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

### src/ekmd_core.sv
// ----------------------------------------------------------------------------
// ekmd_core
// Target update, step remainder, saturation and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ekmd_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             stage_valid,
    input  ekmd_pkg::stage_t                 stage,
    output logic                             core_ready,
    input  logic [ekmd_pkg::DUTY_W-1:0]      max_duty,
    input  logic [ekmd_pkg::DUTY_W-1:0]      min_start_duty,
    output logic                             res_valid,
    input  logic                             res_ready,
    output logic                             drive_forward,
    output logic                             drive_reverse,
    output logic [ekmd_pkg::DUTY_W-1:0]      duty,
    output logic signed [ekmd_pkg::TGT_W-1:0] speed_target
);

    logic signed [ekmd_pkg::TGT_W-1:0]  target_reg;
    logic signed [ekmd_pkg::TGT_W-1:0]  target_next;
    logic signed [ekmd_pkg::REM_W-1:0]  rem_reg;
    logic signed [ekmd_pkg::REM_W-1:0]  rem_next;
    logic                               res_valid_reg;
    logic                               fwd_reg;
    logic                               fwd_next;
    logic                               rev_reg;
    logic                               rev_next;
    logic [ekmd_pkg::DUTY_W-1:0]        duty_reg;
    logic [ekmd_pkg::DUTY_W-1:0]        duty_next;
    logic [ekmd_pkg::SCL_W-1:0]         scaled;
    logic signed [ekmd_pkg::TGT_W-1:0]  target_ui;
    logic signed [ekmd_pkg::ACC_W-1:0]  acc;
    logic signed [ekmd_pkg::ACC_W-1:0]  quot;
    logic signed [ekmd_pkg::SUM_W-1:0]  sum;
    logic signed [ekmd_pkg::SUM_W-1:0]  lim;
    logic [ekmd_pkg::DUTY_W-1:0]        mag;
    logic                               load;

    assign core_ready = !res_valid_reg || res_ready;
    assign load       = stage_valid && core_ready;

    // UI percent to target: product / 100 by reciprocal
    always_comb
    begin
        scaled    = ekmd_pkg::SCL_W'(stage.product) *
                    ekmd_pkg::SCL_W'(ekmd_pkg::PCT_RECIP);
        target_ui = stage.ui_ok ? $signed(ekmd_pkg::TGT_W'(scaled >> ekmd_pkg::PCT_SHIFT))
                                : target_reg;
    end

    // Encoder step: truncating divide of the running count, then saturate
    always_comb
    begin
        acc  = ekmd_pkg::ACC_W'(rem_reg) + ekmd_pkg::ACC_W'(stage.delta);
        quot = ekmd_pkg::ACC_W'(acc / ekmd_pkg::COUNTS_PER_STEP);
        sum  = ekmd_pkg::SUM_W'(target_ui) + ekmd_pkg::SUM_W'(quot);
        lim  = $signed({{(ekmd_pkg::SUM_W-ekmd_pkg::DUTY_W){1'b0}}, max_duty});
        rem_next    = rem_reg;
        target_next = target_ui;
        if (stage.move)
        begin
            rem_next = ekmd_pkg::REM_W'(acc % ekmd_pkg::COUNTS_PER_STEP);
            if (sum > lim)
                target_next = ekmd_pkg::TGT_W'(lim);
            else if (sum < -lim)
                target_next = ekmd_pkg::TGT_W'(-lim);
            else
                target_next = ekmd_pkg::TGT_W'(sum);
        end
    end

    // Bridge direction and duty with start threshold
    always_comb
    begin
        fwd_next  = (target_next > 0);
        rev_next  = (target_next < 0);
        mag       = rev_next ? ekmd_pkg::DUTY_W'(-target_next)
                             : ekmd_pkg::DUTY_W'(target_next);
        duty_next = (mag < min_start_duty) ? '0 : mag;
    end

    // State and result control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            target_reg    <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            if (core_ready)
            begin
                res_valid_reg <= stage_valid;
            end
            if (load)
            begin
                target_reg <= target_next;
                rem_reg    <= rem_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fwd_reg  <= fwd_next;
            rev_reg  <= rev_next;
            duty_reg <= duty_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign drive_forward = fwd_reg;
    assign drive_reverse = rev_reg;
    assign duty          = duty_reg;
    assign speed_target  = target_reg;

endmodule

### src/encoder_knob_motor_drive.sv
// ----------------------------------------------------------------------------
// encoder_knob_motor_drive
// Encoder speed knob driving an H-bridge: target, direction and duty.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one item per tick; tuser is the UI-valid flag, tdata carries the
//   percent and the raw 16-bit encoder count. m_axis: one result item per
//   input item with direction bits, duty and the signed target.
//   APB: max_duty at 0x0, min_start_duty at 0x4; write only while idle.
// Path: input accept to result valid passes the input register, then
//   the update logic feeding the result register.
// Throughput: one item per cycle unless stalled; the update is a single pass of
//   one reciprocal multiply, an add and a clamp between the two registers.
// Reset: target, step remainder and count history clear; the first item
//   after reset captures the encoder count without a step. Registers return to 99/10.
// Stall: when m_tready is low the result register holds, the input
//   register fills behind it, and s_tready drops once both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_knob_motor_drive
(
    input  logic                                clk,
    input  logic                                rst_n,
    // slave stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [6:0] ui_percent, [22:7] encoder_count, [23] zero
    input  logic [ekmd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] ui_valid
    input  logic                                s_axis_tuser,
    // master stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] drive_forward, [1] drive_reverse, [9:2] duty,
    // [18:10] speed_target, [23:19] zero
    output logic [ekmd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ekmd_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [ekmd_pkg::DUTY_W-1:0]         max_duty_reg;
    logic [ekmd_pkg::DUTY_W-1:0]         min_start_reg;
    logic                                cfg_write;
    logic                                stage_valid;
    ekmd_pkg::stage_t                    stage;
    logic                                core_ready;
    logic                                drive_forward;
    logic                                drive_reverse;
    logic [ekmd_pkg::DUTY_W-1:0]         duty;
    logic signed [ekmd_pkg::TGT_W-1:0]   speed_target;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_duty_reg  <= ekmd_pkg::MAX_DUTY_RST;
            min_start_reg <= ekmd_pkg::MIN_START_RST;
        end
        else if (cfg_write)
        begin
            if (paddr == ekmd_pkg::ADDR_MAX_DUTY)
                max_duty_reg <= pwdata[ekmd_pkg::DUTY_W-1:0];
            else if (paddr == ekmd_pkg::ADDR_MIN_START)
                min_start_reg <= pwdata[ekmd_pkg::DUTY_W-1:0];
        end
    end

    // Read back
    always_comb
    begin
        case (paddr)
            ekmd_pkg::ADDR_MAX_DUTY:  prdata = {24'd0, max_duty_reg};
            ekmd_pkg::ADDR_MIN_START: prdata = {24'd0, min_start_reg};
            default:                  prdata = '0;
        endcase
    end

    // Input stage
    ekmd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .ui_valid      (s_axis_tuser),
        .ui_percent    (s_axis_tdata[ekmd_pkg::PCT_W-1:0]),
        .encoder_count (s_axis_tdata[ekmd_pkg::PCT_W +: ekmd_pkg::CNT_W]),
        .max_duty      (max_duty_reg),
        .core_ready    (core_ready),
        .stage_valid   (stage_valid),
        .stage         (stage)
    );

    // Update stage and result register
    ekmd_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .stage_valid    (stage_valid),
        .stage          (stage),
        .core_ready     (core_ready),
        .max_duty       (max_duty_reg),
        .min_start_duty (min_start_reg),
        .res_valid      (m_axis_tvalid),
        .res_ready      (m_axis_tready),
        .drive_forward  (drive_forward),
        .drive_reverse  (drive_reverse),
        .duty           (duty),
        .speed_target   (speed_target)
    );

    assign m_axis_tdata = {5'd0, speed_target, duty, drive_reverse, drive_forward};

endmodule

### src/ekmd_checker.sv
// ----------------------------------------------------------------------------
// ekmd_checker
// Port-level checks of the knob motor drive, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "encoder_knob_motor_drive_defines.svh"

module ekmd_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [ekmd_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    logic                               fwd;
    logic                               rev;
    logic [ekmd_pkg::DUTY_W-1:0]        duty_f;
    logic [ekmd_pkg::TGT_W-1:0]         tgt;
    logic                               duty_on;
    logic                               dir_ok;
    logic                               stalled;
    logic [ekmd_pkg::OUT_DATA_W:0]      res_word;

    // Result item fields
    assign fwd      = m_axis_tdata[0];
    assign rev      = m_axis_tdata[1];
    assign duty_f   = m_axis_tdata[9:2];
    assign tgt      = m_axis_tdata[18:10];
    assign duty_on  = m_axis_tvalid && (duty_f != '0);
    assign dir_ok   = (fwd == (!tgt[ekmd_pkg::TGT_W-1] && (tgt != '0))) &&
                      (rev == tgt[ekmd_pkg::TGT_W-1]);
    assign stalled  = m_axis_tvalid && !m_axis_tready;
    assign res_word = {m_axis_tvalid, m_axis_tdata};

    // Both bridge inputs high would short the supply
    `EKMD_ASSERT_NOW(a_no_shoot, clk, rst_n, m_axis_tvalid, !(fwd && rev), "both drive bits set")

    // Non-zero duty always comes with a direction
    `EKMD_ASSERT_NOW(a_duty_dir, clk, rst_n, duty_on, fwd || rev, "duty without direction")

    // Direction bits follow the sign of the target
    `EKMD_ASSERT_NOW(a_dir_sign, clk, rst_n, m_axis_tvalid, dir_ok, "direction vs target sign")

    // A stalled result item holds
    `EKMD_ASSERT_NEXT(a_hold, clk, rst_n, stalled, $stable(res_word), "stalled item changed")

endmodule

bind encoder_knob_motor_drive ekmd_checker u_ekmd_checker (.*);
